### sv/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Request and response structs, operation codes, table and free-list entries.
// No dependencies.
`default_nettype none

package gha_pkg;

	localparam int MAX_HANDLES = 1024;
	localparam int GEN_BITS    = 16;
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DESTROY = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	typedef struct packed {
		logic [1:0]          operation;
		logic [IDX_W-1:0]    handle_index;
		logic [GEN_BITS-1:0] handle_generation;
	} gha_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]    out_index;
		logic [GEN_BITS-1:0] out_generation;
		logic                handle_ok;
		logic                table_full;
		logic [CNT_W-1:0]    live_count;
	} gha_rsp_t;

	typedef struct packed {
		logic                alive;
		logic [GEN_BITS-1:0] gen;
	} gha_tbl_entry_t;

	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} gha_fifo_entry_t;

	typedef struct packed {
		logic           en;
		logic [IDX_W-1:0] addr;
		gha_tbl_entry_t data;
	} gha_tbl_wr_t;

	typedef struct packed {
		logic            en;
		logic [IDX_W-1:0] addr;
		gha_fifo_entry_t data;
	} gha_fifo_wr_t;

endpackage

`default_nettype wire

### sv/generational_handle_allocator.sv
// Generational handle allocator: top level with handle table and free-index FIFO.
// Depends on gha_pkg for request/response structs and operation codes.
//
// Usage:
//   Requests enter on req_valid/req_stall/req; responses leave on
//   rsp_valid/rsp_stall/rsp. A request is taken at a clock edge with valid high
//   and stall low. Every request yields exactly one response, in order.
//   rsp_valid rises once a taken request is evaluated: the accepting edge
//   reads the handle table and the head of the free FIFO, and the edge at which
//   the evaluation stage fires evaluates the request, writes both memories and
//   loads the response register. Throughput is one request per cycle while
//   rsp_stall is low; a one-entry bypass on each memory covers a write made at
//   the same edge as the following request's read. When rsp_stall holds with
//   rsp_valid high, the response register keeps its value and the evaluation
//   stage holds its request; req_stall rises only when that stage is
//   occupied and cannot advance. Reset clears the FIFO pointers, free count,
//   high-water mark and all valid flags; memory contents are left as they are
//   and never used before written. No clearing pass is needed.
`default_nettype none

module generational_handle_allocator
	import gha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire gha_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output gha_rsp_t      rsp
);

	gha_tbl_entry_t  tbl_mem  [MAX_HANDLES];
	gha_fifo_entry_t fifo_mem [MAX_HANDLES];

	logic            valid_s1;
	gha_req_t        req_s1;
	gha_tbl_entry_t  tbl_rd_s1;
	gha_fifo_entry_t fifo_rd_s1;
	gha_tbl_wr_t     tbl_byp_s1;
	gha_fifo_wr_t    fifo_byp_s1;

	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, hw_q;
	logic             rsp_valid_q;
	gha_rsp_t         rsp_q;

	logic [IDX_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0] count_d, hw_d;
	gha_tbl_wr_t      tbl_wr;
	gha_fifo_wr_t     fifo_wr;
	gha_rsp_t         rsp_d;
	gha_tbl_entry_t   tbl_cur;
	gha_fifo_entry_t  fifo_cur;
	logic [GEN_BITS-1:0] gen_bump;
	logic             handle_valid;
	logic             fire;
	logic             req_acc;

	assign fire      = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !fire;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		tbl_cur = (tbl_byp_s1.en && tbl_byp_s1.addr == req_s1.handle_index) ?
			tbl_byp_s1.data : tbl_rd_s1;
		fifo_cur = (fifo_byp_s1.en && fifo_byp_s1.addr == head_q) ?
			fifo_byp_s1.data : fifo_rd_s1;
		handle_valid = ({1'b0, req_s1.handle_index} < hw_q) && tbl_cur.alive &&
			(req_s1.handle_generation != '0) &&
			(tbl_cur.gen == req_s1.handle_generation);
		gen_bump = fifo_cur.gen + 1'b1;
		if (gen_bump == '0) begin
			gen_bump = GEN_BITS'(1);
		end

		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		hw_d    = hw_q;
		tbl_wr  = '0;
		fifo_wr = '0;
		rsp_d.out_index      = req_s1.handle_index;
		rsp_d.out_generation = req_s1.handle_generation;
		rsp_d.handle_ok      = 1'b0;
		rsp_d.table_full     = 1'b0;

		if (fire) begin
			unique case (req_s1.operation)
				OP_CREATE: begin
					if (count_q != '0) begin
						head_d  = (head_q == IDX_W'(MAX_HANDLES - 1)) ? '0 : head_q + 1'b1;
						count_d = count_q - 1'b1;
						tbl_wr.en         = 1'b1;
						tbl_wr.addr       = fifo_cur.idx;
						tbl_wr.data.alive = 1'b1;
						tbl_wr.data.gen   = gen_bump;
						rsp_d.out_index      = fifo_cur.idx;
						rsp_d.out_generation = gen_bump;
						rsp_d.handle_ok      = 1'b1;
					end else if (hw_q != CNT_W'(MAX_HANDLES)) begin
						hw_d = hw_q + 1'b1;
						tbl_wr.en         = 1'b1;
						tbl_wr.addr       = hw_q[IDX_W-1:0];
						tbl_wr.data.alive = 1'b1;
						tbl_wr.data.gen   = GEN_BITS'(1);
						rsp_d.out_index      = hw_q[IDX_W-1:0];
						rsp_d.out_generation = GEN_BITS'(1);
						rsp_d.handle_ok      = 1'b1;
					end else begin
						rsp_d.table_full = 1'b1;
					end
				end
				OP_DESTROY: begin
					if (handle_valid) begin
						tbl_wr.en         = 1'b1;
						tbl_wr.addr       = req_s1.handle_index;
						tbl_wr.data.alive = 1'b0;
						tbl_wr.data.gen   = req_s1.handle_generation;
						fifo_wr.en        = 1'b1;
						fifo_wr.addr      = tail_q;
						fifo_wr.data.idx  = req_s1.handle_index;
						fifo_wr.data.gen  = req_s1.handle_generation;
						tail_d  = (tail_q == IDX_W'(MAX_HANDLES - 1)) ? '0 : tail_q + 1'b1;
						count_d = count_q + 1'b1;
						rsp_d.handle_ok = 1'b1;
					end
				end
				OP_CHECK: begin
					rsp_d.handle_ok = handle_valid;
				end
				OP_CLEAR: begin
					head_d  = '0;
					tail_d  = '0;
					count_d = '0;
					hw_d    = '0;
				end
				default: begin
				end
			endcase
		end
		rsp_d.live_count = hw_d - count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			hw_q        <= '0;
			tbl_byp_s1  <= '0;
			fifo_byp_s1 <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			hw_q    <= hw_d;
			if (req_acc) begin
				valid_s1    <= 1'b1;
				tbl_byp_s1  <= tbl_wr;
				fifo_byp_s1 <= fifo_wr;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr.en) begin
			tbl_mem[tbl_wr.addr] <= tbl_wr.data;
		end
		if (fifo_wr.en) begin
			fifo_mem[fifo_wr.addr] <= fifo_wr.data;
		end
		if (req_acc) begin
			req_s1     <= req;
			tbl_rd_s1  <= tbl_mem[req.handle_index];
			fifo_rd_s1 <= fifo_mem[head_d];
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	a_free_le_hw: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hw_q)
		else $error("free count exceeds high-water mark");

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CNT_W'(MAX_HANDLES))
		else $error("high-water mark beyond capacity");

	a_ok_gen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.handle_ok |-> rsp_q.out_generation != '0 && !rsp_q.table_full)
		else $error("successful request with zero generation or full flag");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(req_s1))
		else $error("held request changed in evaluation stage");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> !tbl_wr.en && !fifo_wr.en && head_d == head_q && hw_d == hw_q)
		else $error("state changed without an evaluated request");

endmodule

`default_nettype wire
